// ===== rtl/quad_batch_vertex_expander_top_macros.svh =====
// Assertion macros for the quad batch vertex expander.
// Used by the top level; needs a clk and rst in scope.
`ifndef QUAD_BATCH_VERTEX_EXPANDER_TOP_MACROS_SVH
`define QUAD_BATCH_VERTEX_EXPANDER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QBVE_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define QBVE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define QBVE_ASSERT_NOW(lbl, a, b)
`define QBVE_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== rtl/qbve_pkg.sv =====
// Shared constants, types and the sine table for the quad batch vertex expander.
// No dependencies.
package qbve_pkg;

  localparam int MAX_QUADS       = 16384;
  localparam int TEXTURE_SLOTS   = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SLOT_W    = 5;
  localparam int SLOT_CNT_W = SLOT_W + 1;
  localparam int QUADS_W   = 15;
  localparam int SIN_SHIFT = 16 - SINE_TABLE_BITS;
  localparam int SIN_STEPS = 1 << (SINE_TABLE_BITS - 2);
  localparam int SIN_IDX_W = SINE_TABLE_BITS - 1;

  localparam logic [16:0] SIN_ONE = 17'd65536;
  localparam logic        OP_DRAW = 1'b0;
  localparam logic        OP_END  = 1'b1;
  localparam logic        KIND_VERTEX = 1'b0;
  localparam logic        KIND_FLUSH  = 1'b1;
  localparam logic [31:0] WHITE = 32'hFFFF_FFFF;
  localparam logic [15:0] TILING_ONE = 16'd256;

  localparam longint unsigned C1 = 64'd1686629713;
  localparam longint unsigned C3 = 64'd693598669;
  localparam longint unsigned C5 = 64'd85569306;
  localparam longint unsigned C7 = 64'd5026995;
  localparam longint unsigned C9 = 64'd172272;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } slot_chain_t;

  typedef logic [16:0] sin_tab_t [SIN_STEPS];

  function automatic logic [16:0] sin_entry(int unsigned idx);
    longint unsigned x, x2, p, res;
    x   = longint'(idx) << (SIN_SHIFT + 16);
    x2  = (x * x) >> 30;
    p   = C9;
    p   = C7 - ((p * x2) >> 30);
    p   = C5 - ((p * x2) >> 30);
    p   = C3 - ((p * x2) >> 30);
    p   = C1 - ((p * x2) >> 30);
    res = (((p * x) >> 30) + 64'd8192) >> 14;
    if (res > 64'd65536) res = 64'd65536;
    return res[16:0];
  endfunction

  function automatic sin_tab_t sin_tab_build();
    sin_tab_t t;
    for (int i = 0; i < SIN_STEPS; i++) t[i] = sin_entry(i);
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = sin_tab_build();

  // Signed Q1.16 sine of a turn fraction, quarter-wave table with folding.
  function automatic logic signed [17:0] sine_q16(logic [15:0] a);
    logic [15:0]          at;
    logic [14:0]          rf;
    logic [SIN_IDX_W-1:0] idx;
    logic [16:0]          mag;
    at  = {a[15:SIN_SHIFT], SIN_SHIFT'(0)};
    rf  = at[14] ? (15'd16384 - {1'b0, at[13:0]}) : {1'b0, at[13:0]};
    idx = SIN_IDX_W'(rf >> SIN_SHIFT);
    mag = (idx == SIN_IDX_W'(SIN_STEPS)) ? SIN_ONE : SIN_TAB[idx[SIN_IDX_W-2:0]];
    return at[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ===== rtl/qbve_if.sv =====
// Command and result channel interfaces for the quad batch vertex expander.
// No dependencies.
interface qbve_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] size_w;
  logic signed [31:0] size_h;
  logic [15:0]        angle;
  logic [31:0]        color_rgba;
  logic               textured;
  logic [31:0]        texture_id;
  logic [15:0]        tiling;
  modport source (output valid, operation, pos_x, pos_y, pos_z, size_w, size_h, angle,
                  color_rgba, textured, texture_id, tiling, input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, size_w, size_h, angle,
                color_rgba, textured, texture_id, tiling, output ready);
endinterface

interface qbve_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic               tex_u;
  logic               tex_v;
  logic [31:0]        vert_color;
  logic [4:0]         slot;
  logic [15:0]        vert_tiling;
  logic [16:0]        index_count;
  logic [5:0]         slots_used;
  logic               last;
  modport source (output valid, kind, vert_x, vert_y, vert_z, tex_u, tex_v, vert_color,
                  slot, vert_tiling, index_count, slots_used, last, input ready);
  modport sink (input valid, kind, vert_x, vert_y, vert_z, tex_u, tex_v, vert_color,
                slot, vert_tiling, index_count, slots_used, last, output ready);
endinterface

// ===== rtl/quad_batch_vertex_expander_top.sv =====
// Quad batch vertex expander top level: sequencer, shared multiplier, result register.
// Depends on qbve_pkg, qbve_if, qbve_slot_row and the assertion macro header.
//
// Usage:
//   in_ch carries one command per beat: a draw quad or an end of scene.
//   out_ch carries results: a draw gives four vertex beats, preceded by a
//   flush beat when the batch or the texture slot table is full; an end of
//   scene gives one flush beat. last marks the final beat of a command.
//   A command passes an accept state, a slot lookup and sine state, four
//   products on the shared 32x18 multiplier for w*cos, w*sin, h*cos, h*sin,
//   then the state that emits its result beats; an end of scene skips the
//   multiplier and goes straight to the emit state.
//   The next command is taken while the last result beat still waits.
//   Slot search runs combinationally as a chain through 32 slot cells.
//   Reset (rst, synchronous) empties the batch and sets the next slot to 1;
//   the slot table needs no clearing. When the receiver stalls, the result
//   register holds its beat and the sequencer waits.
`include "quad_batch_vertex_expander_top_macros.svh"
module quad_batch_vertex_expander_top (
  input logic        clk,
  input logic        rst,
  qbve_in_if.sink    in_ch,
  qbve_out_if.source out_ch
);
  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_MUL, S_EMIT} state_t;

  state_t state;
  logic [qbve_pkg::QUADS_W-1:0]    batch_quads;
  logic [qbve_pkg::SLOT_CNT_W-1:0] next_slot;

  logic               op_end_r, textured_r;
  logic signed [31:0] px_r, py_r, pz_r, w_r, h_r;
  logic [15:0]        angle_r, til_r;
  logic [31:0]        col_r, id_r;
  logic signed [17:0] sin_r, cos_r;
  logic signed [49:0] prod_r [4];
  logic [1:0]         mcnt, corner;
  logic               flush_pend;
  logic [16:0]        flush_idx;
  logic [5:0]         flush_used;
  logic [qbve_pkg::SLOT_W-1:0] slot_r;

  logic o_valid;

  logic batch_full, tbl_full, row_we, can_load, sx_neg, sy_neg;
  logic [qbve_pkg::SLOT_CNT_W-1:0] ns_eff, base;
  qbve_pkg::slot_chain_t srch;
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod;
  logic signed [51:0] wc, ws, hc, hs, dxs, dys;

  assign batch_full = batch_quads >= qbve_pkg::QUADS_W'(qbve_pkg::MAX_QUADS);
  assign ns_eff     = batch_full ? qbve_pkg::SLOT_CNT_W'(1) : next_slot;
  assign tbl_full   = textured_r && !srch.found &&
                      (ns_eff >= qbve_pkg::SLOT_CNT_W'(qbve_pkg::TEXTURE_SLOTS));
  assign base       = tbl_full ? qbve_pkg::SLOT_CNT_W'(1) : ns_eff;
  assign row_we     = (state == S_LOOK) && !op_end_r && textured_r && !srch.found;

  qbve_slot_row u_row (
    .clk     (clk),
    .we      (row_we),
    .wr_slot (base[qbve_pkg::SLOT_W-1:0]),
    .wr_id   (id_r),
    .id      (id_r),
    .limit   (ns_eff),
    .result  (srch)
  );

  assign mul_a = mcnt[1] ? h_r : w_r;
  assign mul_b = mcnt[0] ? sin_r : cos_r;
  assign prod  = mul_a * mul_b;

  assign wc = 52'(prod_r[0]);
  assign ws = 52'(prod_r[1]);
  assign hc = 52'(prod_r[2]);
  assign hs = 52'(prod_r[3]);
  assign sx_neg = (corner == 2'd0) || (corner == 2'd3);
  assign sy_neg = (corner == 2'd0) || (corner == 2'd1);
  assign dxs = (sx_neg ? -wc : wc) - (sy_neg ? -hs : hs) + 52'sd65536;
  assign dys = (sx_neg ? -ws : ws) + (sy_neg ? -hc : hc) + 52'sd65536;

  assign can_load    = !o_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      o_valid     <= 1'b0;
      batch_quads <= '0;
      next_slot   <= qbve_pkg::SLOT_CNT_W'(1);
      flush_pend  <= 1'b0;
    end else begin
      if (o_valid && out_ch.ready && (state != S_EMIT)) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_end_r   <= (in_ch.operation == qbve_pkg::OP_END);
            textured_r <= in_ch.textured;
            px_r    <= in_ch.pos_x;
            py_r    <= in_ch.pos_y;
            pz_r    <= in_ch.pos_z;
            w_r     <= in_ch.size_w;
            h_r     <= in_ch.size_h;
            angle_r <= in_ch.angle;
            id_r    <= in_ch.texture_id;
            col_r   <= in_ch.textured ? qbve_pkg::WHITE : in_ch.color_rgba;
            til_r   <= in_ch.textured ? in_ch.tiling : qbve_pkg::TILING_ONE;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          flush_idx  <= ({2'b0, batch_quads} << 2) + ({2'b0, batch_quads} << 1);
          flush_used <= next_slot;
          sin_r      <= qbve_pkg::sine_q16(angle_r);
          cos_r      <= qbve_pkg::sine_q16(angle_r + 16'd16384);
          mcnt       <= 2'd0;
          corner     <= 2'd0;
          if (op_end_r) begin
            flush_pend  <= 1'b1;
            batch_quads <= '0;
            next_slot   <= qbve_pkg::SLOT_CNT_W'(1);
            state       <= S_EMIT;
          end else begin
            flush_pend  <= batch_full || tbl_full;
            batch_quads <= ((batch_full || tbl_full) ? '0 : batch_quads) +
                           qbve_pkg::QUADS_W'(1);
            if (!textured_r) begin
              slot_r    <= '0;
              next_slot <= ns_eff;
            end else if (srch.found) begin
              slot_r    <= srch.slot;
              next_slot <= ns_eff;
            end else begin
              slot_r    <= base[qbve_pkg::SLOT_W-1:0];
              next_slot <= base + qbve_pkg::SLOT_CNT_W'(1);
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r[mcnt] <= prod;
          mcnt         <= mcnt + 2'd1;
          if (mcnt == 2'd3) state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            o_valid <= 1'b1;
            if (flush_pend) begin
              flush_pend         <= 1'b0;
              out_ch.kind        <= qbve_pkg::KIND_FLUSH;
              out_ch.vert_x      <= '0;
              out_ch.vert_y      <= '0;
              out_ch.vert_z      <= '0;
              out_ch.tex_u       <= 1'b0;
              out_ch.tex_v       <= 1'b0;
              out_ch.vert_color  <= '0;
              out_ch.slot        <= '0;
              out_ch.vert_tiling <= '0;
              out_ch.index_count <= flush_idx;
              out_ch.slots_used  <= flush_used;
              out_ch.last        <= op_end_r;
              if (op_end_r) state <= S_IDLE;
            end else begin
              out_ch.kind        <= qbve_pkg::KIND_VERTEX;
              out_ch.vert_x      <= px_r + dxs[48:17];
              out_ch.vert_y      <= py_r + dys[48:17];
              out_ch.vert_z      <= pz_r;
              out_ch.tex_u       <= (corner == 2'd1) || (corner == 2'd2);
              out_ch.tex_v       <= corner[1];
              out_ch.vert_color  <= col_r;
              out_ch.slot        <= slot_r;
              out_ch.vert_tiling <= til_r;
              out_ch.index_count <= '0;
              out_ch.slots_used  <= '0;
              out_ch.last        <= (corner == 2'd3);
              corner             <= corner + 2'd1;
              if (corner == 2'd3) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `QBVE_ASSERT_NOW(a_slot_bound, 1'b1, next_slot <= qbve_pkg::SLOT_CNT_W'(qbve_pkg::TEXTURE_SLOTS))
  `QBVE_ASSERT_NOW(a_quad_bound, 1'b1, batch_quads <= qbve_pkg::QUADS_W'(qbve_pkg::MAX_QUADS))
  `QBVE_ASSERT_NEXT(a_accept_look, in_ch.valid && in_ch.ready, state == S_LOOK)
  `QBVE_ASSERT_NOW(a_flush_zero, o_valid && (out_ch.kind == qbve_pkg::KIND_FLUSH), out_ch.slot == '0)
  `QBVE_ASSERT_NOW(a_vert_counts, o_valid && (out_ch.kind == qbve_pkg::KIND_VERTEX), out_ch.slots_used == '0)

endmodule

// ===== rtl/qbve_slot_cell.sv =====
// One texture slot cell: holds one table entry and passes the first-match chain on.
// Depends on qbve_pkg.
module qbve_slot_cell (
  input  logic                           clk,
  input  logic                           we,
  input  logic [31:0]                    wr_id,
  input  logic [31:0]                    id,
  input  logic [qbve_pkg::SLOT_W-1:0]    index,
  input  logic [qbve_pkg::SLOT_CNT_W-1:0] limit,
  input  qbve_pkg::slot_chain_t          chain_in,
  output qbve_pkg::slot_chain_t          chain_out
);
  logic [31:0] entry;
  logic        hit;

  always_ff @(posedge clk) begin
    if (we) entry <= wr_id;
  end

  assign hit = (index != '0) && ({1'b0, index} < limit) && (entry == id);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && hit) begin
      chain_out.found = 1'b1;
      chain_out.slot  = index;
    end
  end
endmodule

// ===== rtl/qbve_slot_row.sv =====
// Row of texture slot cells: write decode and first-match search.
// Depends on qbve_pkg and qbve_slot_cell.
module qbve_slot_row (
  input  logic                            clk,
  input  logic                            we,
  input  logic [qbve_pkg::SLOT_W-1:0]     wr_slot,
  input  logic [31:0]                     wr_id,
  input  logic [31:0]                     id,
  input  logic [qbve_pkg::SLOT_CNT_W-1:0] limit,
  output qbve_pkg::slot_chain_t           result
);
  qbve_pkg::slot_chain_t chain [qbve_pkg::TEXTURE_SLOTS+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < qbve_pkg::TEXTURE_SLOTS; i++) begin : g_cell
    qbve_slot_cell u_cell (
      .clk       (clk),
      .we        (we && (wr_slot == qbve_pkg::SLOT_W'(i))),
      .wr_id     (wr_id),
      .id        (id),
      .index     (qbve_pkg::SLOT_W'(i)),
      .limit     (limit),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign result = chain[qbve_pkg::TEXTURE_SLOTS];
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for quad_batch_vertex_expander_top: directed and random quads,
// slot-table overflow, with random idle on both channels.
// Depends on qbve_pkg, qbve_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               op;
    logic signed [31:0] px, py, pz, w, h;
    logic [15:0]        angle;
    logic [31:0]        color;
    logic               textured;
    logic [31:0]        tex_id;
    logic [15:0]        tiling;
  } quad_cmd_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] x, y, z;
    logic               u, v;
    logic [31:0]        color;
    logic [4:0]         slot;
    logic [15:0]        tiling;
    logic [16:0]        idx_cnt;
    logic [5:0]         used;
    logic               last;
  } vertex_beat_t;

  logic clk = 1'b0;
  logic rst;
  qbve_in_if  cmd_ch();
  qbve_out_if vtx_ch();

  quad_batch_vertex_expander_top dut (.clk(clk), .rst(rst), .in_ch(cmd_ch), .out_ch(vtx_ch));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vertex_beat_t   pending_beats[$];
  int unsigned    batch_quads_m;
  int unsigned    next_slot_m;
  logic [31:0]    slot_ids[32];
  bit             idle_on = 1'b1;
  int unsigned    errors, n_cmds, n_beats, n_flushes, stall_left, quiet_cycles;

  function automatic longint sine_turn(logic [15:0] a);
    longint unsigned x, x2, p, res;
    logic [15:0] at;
    logic [13:0] r;
    at = (a >> qbve_pkg::SIN_SHIFT) << qbve_pkg::SIN_SHIFT;
    r  = at[13:0];
    x  = at[14] ? longint'(16384 - r) : longint'(r);
    x  = x << 16;
    x2 = (x * x) >> 30;
    p  = qbve_pkg::C9;
    p  = qbve_pkg::C7 - ((p * x2) >> 30);
    p  = qbve_pkg::C5 - ((p * x2) >> 30);
    p  = qbve_pkg::C3 - ((p * x2) >> 30);
    p  = qbve_pkg::C1 - ((p * x2) >> 30);
    res = (((p * x) >> 30) + 8192) >> 14;
    if (res > 65536) res = 65536;
    return at[15] ? -longint'(res) : longint'(res);
  endfunction

  function automatic void push_flush();
    vertex_beat_t b;
    b = '{kind: qbve_pkg::KIND_FLUSH, idx_cnt: 17'(batch_quads_m * 6),
          used: 6'(next_slot_m), default: '0};
    pending_beats.push_back(b);
    n_flushes++;
    batch_quads_m = 0;
    next_slot_m = 1;
  endfunction

  function automatic void predict_quad(quad_cmd_t c);
    vertex_beat_t b;
    int unsigned  slot;
    longint       sn, cs, lx, ly, dx, dy;
    logic [31:0]  col;
    logic [15:0]  til;
    if (c.op == qbve_pkg::OP_END) begin
      push_flush();
      pending_beats[$].last = 1'b1;
      return;
    end
    if (batch_quads_m >= qbve_pkg::MAX_QUADS) push_flush();
    slot = 0;
    col = c.color;
    til = qbve_pkg::TILING_ONE;
    if (c.textured) begin
      for (int i = 1; i < next_slot_m && i < qbve_pkg::TEXTURE_SLOTS; i++)
        if (slot == 0 && slot_ids[i] == c.tex_id) slot = i;
      if (slot == 0) begin
        if (next_slot_m >= qbve_pkg::TEXTURE_SLOTS) push_flush();
        slot = next_slot_m;
        slot_ids[slot % 32] = c.tex_id;
        next_slot_m++;
      end
      col = qbve_pkg::WHITE;
      til = c.tiling;
    end
    sn = sine_turn(c.angle);
    cs = sine_turn(c.angle + 16'd16384);
    for (int k = 0; k < 4; k++) begin
      lx = (k == 0 || k == 3) ? -longint'(c.w) : longint'(c.w);
      ly = (k < 2) ? -longint'(c.h) : longint'(c.h);
      dx = (lx * cs - ly * sn + 65536) >>> 17;
      dy = (lx * sn + ly * cs + 65536) >>> 17;
      b = '{kind: qbve_pkg::KIND_VERTEX, x: 32'(longint'(c.px) + dx),
            y: 32'(longint'(c.py) + dy), z: c.pz, u: (k == 1 || k == 2), v: (k >= 2),
            color: col, slot: 5'(slot), tiling: til, idx_cnt: '0, used: '0, last: 1'b0};
      pending_beats.push_back(b);
    end
    pending_beats[$].last = 1'b1;
    batch_quads_m++;
  endfunction

  task automatic send_cmd(quad_cmd_t c);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= c.op;
    cmd_ch.pos_x      <= c.px;
    cmd_ch.pos_y      <= c.py;
    cmd_ch.pos_z      <= c.pz;
    cmd_ch.size_w     <= c.w;
    cmd_ch.size_h     <= c.h;
    cmd_ch.angle      <= c.angle;
    cmd_ch.color_rgba <= c.color;
    cmd_ch.textured   <= c.textured;
    cmd_ch.texture_id <= c.tex_id;
    cmd_ch.tiling     <= c.tiling;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_quad(c);
    n_cmds++;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic quad_cmd_t rand_quad(bit tex, logic [31:0] id);
    quad_cmd_t c;
    c = '{op: qbve_pkg::OP_DRAW, px: $urandom, py: $urandom, pz: $urandom, w: $urandom,
          h: $urandom, angle: 16'($urandom), color: $urandom, textured: tex, tex_id: id,
          tiling: 16'($urandom)};
    if ($urandom_range(0, 1)) begin
      c.w = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.h = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    return c;
  endfunction

  function automatic quad_cmd_t end_scene();
    quad_cmd_t c;
    c = rand_quad(1'($urandom_range(0, 1)), $urandom);
    c.op = qbve_pkg::OP_END;
    return c;
  endfunction

  task automatic field_check(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    vertex_beat_t e;
    if (rst) begin
      vtx_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (vtx_ch.valid && vtx_ch.ready) begin
        n_beats++;
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got kind %0b", $time, vtx_ch.kind);
        end else begin
          e = pending_beats.pop_front();
          field_check("kind", e.kind, vtx_ch.kind);
          field_check("vert_x", 32'(e.x), 32'(vtx_ch.vert_x));
          field_check("vert_y", 32'(e.y), 32'(vtx_ch.vert_y));
          field_check("vert_z", 32'(e.z), 32'(vtx_ch.vert_z));
          field_check("tex_u", e.u, vtx_ch.tex_u);
          field_check("tex_v", e.v, vtx_ch.tex_v);
          field_check("vert_color", e.color, vtx_ch.vert_color);
          field_check("slot", e.slot, vtx_ch.slot);
          field_check("vert_tiling", e.tiling, vtx_ch.vert_tiling);
          field_check("index_count", e.idx_cnt, vtx_ch.index_count);
          field_check("slots_used", e.used, vtx_ch.slots_used);
          field_check("last", e.last, vtx_ch.last);
        end
        stall_left = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        vtx_ch.ready <= 1'b0;
      end else begin
        vtx_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (vtx_ch.valid && vtx_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("%0t: timeout, %0d beats outstanding", $time, pending_beats.size());
      $display("** quad_batch_vertex_expander_top: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    quad_cmd_t c;
    logic [15:0] angles[7] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd1, 16'hFFFF,
                               16'd8192};
    foreach (angles[i]) begin
      c = rand_quad(1'(i % 2), 32'hA0 + i);
      c.angle = angles[i];
      c.w = 32'sh0001_0000;
      c.h = 32'sh0002_0000;
      send_cmd(c);
    end
    c = rand_quad(1'b1, 32'hFFFF_FFFF);
    c.px = 32'sh7FFF_FFFF; c.py = 32'sh8000_0000; c.pz = 32'sh8000_0000;
    c.w = 32'sh7FFF_FFFF; c.h = 32'sh8000_0000; c.tiling = 16'hFFFF;
    send_cmd(c);
    c = rand_quad(1'b1, 32'h0);
    c.px = 32'sh8000_0000; c.py = 32'sh7FFF_FFFF; c.pz = 32'sh7FFF_FFFF;
    c.w = 32'sh8000_0000; c.h = 32'sh7FFF_FFFF; c.tiling = 16'h0; c.angle = 16'd24576;
    send_cmd(c);
    c = rand_quad(1'b1, 32'hA1);
    send_cmd(c);
    c = rand_quad(1'b0, 32'h0);
    c.w = 0; c.h = 0; c.color = 32'h0;
    send_cmd(c);
    c = rand_quad(1'b0, 32'h0);
    c.color = 32'hFFFF_FFFF;
    send_cmd(c);
    send_cmd(end_scene());
    send_cmd(end_scene());
    drain();
  endtask

  task automatic test_slot_table_full();
    for (int i = 0; i < 31; i++) send_cmd(rand_quad(1'b1, 32'h1000 + i));
    send_cmd(rand_quad(1'b1, 32'h1005));
    send_cmd(rand_quad(1'b1, 32'h101E));
    send_cmd(rand_quad(1'b1, 32'h2000));
    send_cmd(rand_quad(1'b1, 32'h1001));
    send_cmd(end_scene());
    drain();
  endtask

  task automatic test_random();
    logic [31:0] ids[8];
    int unsigned pick;
    foreach (ids[i]) ids[i] = $urandom;
    for (int n = 0; n < 200; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_cmd(end_scene());
      else if (pick < 40) send_cmd(rand_quad(1'b0, $urandom));
      else if (pick < 80) send_cmd(rand_quad(1'b1, ids[$urandom_range(0, 7)]));
      else send_cmd(rand_quad(1'b1, $urandom));
      if (n == 120) begin
        cmd_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
      end
      if (n % 50 == 25) idle_on = 1'b0;
      if (n % 50 == 40) idle_on = 1'b1;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.operation <= qbve_pkg::OP_DRAW;
    cmd_ch.pos_x <= '0; cmd_ch.pos_y <= '0; cmd_ch.pos_z <= '0;
    cmd_ch.size_w <= '0; cmd_ch.size_h <= '0; cmd_ch.angle <= '0;
    cmd_ch.color_rgba <= '0; cmd_ch.textured <= 1'b0;
    cmd_ch.texture_id <= '0; cmd_ch.tiling <= '0;
    batch_quads_m = 0;
    next_slot_m = 1;
    foreach (slot_ids[i]) slot_ids[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slot_table_full();
    test_random();
    $display("Run covered %0d commands, %0d result beats, %0d flushes,", n_cmds, n_beats,
             n_flushes);
    $display("including slot-table overflow and end-of-scene, with %0d mismatches.", errors);
    if (errors == 0 && pending_beats.size() == 0)
      $display("** quad_batch_vertex_expander_top: PASSED **");
    else
      $display("** quad_batch_vertex_expander_top: FAILED **");
    $finish;
  end
endmodule
